// ===== rtl/ycc2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared types and constants of the YCbCr to RGB pixel converter.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

    localparam int unsigned DIM_W     = 16;
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned PIXEL_W   = 24;
    localparam int unsigned OFFSET_W  = 32;
    localparam int unsigned REG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd2;

    localparam logic [SAMPLE_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [SAMPLE_W-1:0] CHANNEL_MAX = 8'hFF;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 16'd0;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 16'd1;
    localparam logic [DIM_W-1:0] LINE_STRIDE_RESET  = 16'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] blue_diff;
        logic [SAMPLE_W-1:0] red_diff;
    } ycc_sample_t;

endpackage

// ===== rtl/ycbcr_to_rgb_pixel_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_converter
// Converts a raster stream of YCbCr pixels to packed RGB words with their
// destination offsets and an end-of-image mark.
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the result register
// throughput: one pixel per cycle while the result is not stalled; the color math
//   and the stride multiply each sit in the single stage between the two registers
// reset: counters clear to zero, width 0, height 1, stride 0; no pipeline flush
//   beyond clearing the stage valids
module ycbcr_to_rgb_pixel_converter
    import ycc2rgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   luma,
    input  logic [SAMPLE_W-1:0]   blue_diff,
    input  logic [SAMPLE_W-1:0]   red_diff,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIXEL_W-1:0]    pixel_word,
    output logic [OFFSET_W-1:0]   dest_offset,
    output logic                  end_of_image
);

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [DIM_W-1:0]    stride_reg;
    logic [DIM_W-1:0]    col_reg;
    logic [DIM_W-1:0]    col_next;
    logic [DIM_W-1:0]    row_reg;
    logic [DIM_W-1:0]    row_next;

    logic                s1_valid_reg;
    ycc_sample_t         s1_sample_reg;
    logic [DIM_W-1:0]    s1_col_reg;
    logic [DIM_W-1:0]    s1_row_reg;
    logic                s1_last_reg;

    logic                s2_valid_reg;
    logic [PIXEL_W-1:0]  s2_pixel_reg;
    logic [OFFSET_W-1:0] s2_offset_reg;
    logic                s2_last_reg;

    logic                in_accept;
    logic                s2_load;
    logic [DIM_W-1:0]    height_eff;
    logic                last_col;
    logic                last_row;
    logic                last_pixel;
    logic [PIXEL_W-1:0]  conv_pixel;
    logic [OFFSET_W-1:0] offset_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            stride_reg <= LINE_STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_LINE_STRIDE:  stride_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign s2_load   = !s2_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_load;
    assign in_accept = in_valid && in_ready;

    // raster position of the incoming pixel
    assign height_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
    assign last_col   = ({1'b0, col_reg} + 17'd1) >= {1'b0, width_reg};
    assign last_row   = ({1'b0, row_reg} + 17'd1) >= {1'b0, height_eff};
    assign last_pixel = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (!last_col)
                col_next = col_reg + DIM_W'(1);
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= '{luma: luma, blue_diff: blue_diff, red_diff: red_diff};
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_last_reg   <= last_pixel;
        end
    end

    ycc2rgb_conv u_conv (
        .sample     (s1_sample_reg),
        .pixel_word (conv_pixel)
    );

    assign offset_next = (OFFSET_W'(stride_reg) * OFFSET_W'(s1_row_reg))
                       + OFFSET_W'(s1_col_reg);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_load)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_pixel_reg  <= conv_pixel;
            s2_offset_reg <= offset_next;
            s2_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign pixel_word   = s2_pixel_reg;
    assign dest_offset  = s2_offset_reg;
    assign end_of_image = s2_last_reg;

    // counters wrap to the image origin after the last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_pixel) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after last pixel");

    // inside a row the column steps by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !last_col) |=> (col_reg == $past(col_reg) + DIM_W'(1)
                                      && row_reg == $past(row_reg)))
        else $error("column did not advance");

    // input stalls only when the input register is held by a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && !out_ready))
        else $error("input stalled without back pressure");

    // a held pixel in the input register is not lost while the result stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> s1_valid_reg)
        else $error("staged pixel dropped");

endmodule

// ===== rtl/ycc2rgb_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycc2rgb_conv
// Shift-and-add YCbCr to RGB conversion with clamping, packed as B/G/R.
// ----------------------------------------------------------------------------
module ycc2rgb_conv
    import ycc2rgb_pkg::*;
(
    input  ycc_sample_t          sample,
    output logic [PIXEL_W-1:0]   pixel_word
);

    logic signed [10:0] y_ext;
    logic signed [10:0] c_ext;
    logic signed [10:0] d_ext;
    logic signed [8:0]  c_diff;
    logic signed [8:0]  d_diff;
    logic signed [10:0] red_sum;
    logic signed [10:0] green_sum;
    logic signed [10:0] blue_sum;

    function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [10:0] v);
        logic [SAMPLE_W-1:0] res;
        begin
            if (v[10])
                res = '0;
            else if (v[9:8] != 2'b00)
                res = CHANNEL_MAX;
            else
                res = v[7:0];
            return res;
        end
    endfunction

    assign c_diff = signed'({1'b0, sample.blue_diff}) - signed'({1'b0, CHROMA_BIAS});
    assign d_diff = signed'({1'b0, sample.red_diff}) - signed'({1'b0, CHROMA_BIAS});
    assign y_ext  = signed'({3'b000, sample.luma});
    assign c_ext  = {{2{c_diff[8]}}, c_diff};
    assign d_ext  = {{2{d_diff[8]}}, d_diff};

    // arithmetic shifts give the floor of the scaled chroma
    assign red_sum   = y_ext + d_ext + (d_ext >>> 2) + (d_ext >>> 3) + (d_ext >>> 5);
    assign green_sum = y_ext - ((c_ext >>> 2) + (c_ext >>> 4) + (c_ext >>> 5))
                             - ((d_ext >>> 1) + (d_ext >>> 3) + (d_ext >>> 4) + (d_ext >>> 5));
    assign blue_sum  = y_ext + c_ext + (c_ext >>> 1) + (c_ext >>> 2) + (c_ext >>> 6);

    assign pixel_word = {clamp_channel(blue_sum), clamp_channel(green_sum),
                         clamp_channel(red_sum)};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YCbCr to RGB pixel converter. Pixel requests
// are fed from a queue through a valid/ready driver with random gaps. Every
// accepted pixel is run through a local model of the color math and of the
// raster counters. A monitor checks each result against the oldest pending
// expectation. Image sizes and stride are reprogrammed between phases,
// zero and maximum values included.
// ----------------------------------------------------------------------------
module tb_top;
    import ycc2rgb_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel_word;
        logic [OFFSET_W-1:0] dest_offset;
        logic                end_of_image;
    } rgb_result_t;

    localparam int RANDOM_PIXELS = 1190;
    localparam int MAX_PRINTS    = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  luma = '0;
    logic [SAMPLE_W-1:0]  blue_diff = '0;
    logic [SAMPLE_W-1:0]  red_diff = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIXEL_W-1:0]   pixel_word;
    logic [OFFSET_W-1:0]  dest_offset;
    logic                 end_of_image;

    ycbcr_to_rgb_pixel_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .luma         (luma),
        .blue_diff    (blue_diff),
        .red_diff     (red_diff),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .dest_offset  (dest_offset),
        .end_of_image (end_of_image)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ycc_sample_t pending_pixels[$];
    rgb_result_t expected_pixels[$];

    // local copies of the registers and the raster position
    logic [DIM_W-1:0] model_width  = IMAGE_WIDTH_RESET;
    logic [DIM_W-1:0] model_height = IMAGE_HEIGHT_RESET;
    logic [DIM_W-1:0] model_stride = LINE_STRIDE_RESET;
    logic [DIM_W-1:0] col_pos = '0;
    logic [DIM_W-1:0] row_pos = '0;

    int  error_count = 0;
    int  pixels_checked = 0;
    int  images_done = 0;
    int  phase_count = 0;
    int  random_pixels = 0;
    int  phase_len;
    int  split_at;
    int  k;
    bit  calm = 1'b0;
    bit  sample_taken = 1'b0;
    int  in_gap_left = 0;
    int  out_stall_left = 0;
    ycc_sample_t next_sample;
    ycc_sample_t taken_sample;
    rgb_result_t want;

    function automatic logic [7:0] clamp_channel(int v);
        if (v > int'(CHANNEL_MAX))
            return CHANNEL_MAX;
        if (v < 0)
            return 8'd0;
        return v[7:0];
    endfunction

    // color math plus raster counter advance for one accepted pixel
    function automatic rgb_result_t convert_and_advance(ycc_sample_t s);
        int          y;
        int          c;
        int          d;
        int          r;
        int          g;
        int          b;
        int          height;
        bit          last_col;
        bit          last_row;
        rgb_result_t res;
        y = int'(s.luma);
        c = int'(s.blue_diff) - int'(CHROMA_BIAS);
        d = int'(s.red_diff) - int'(CHROMA_BIAS);
        r = y + d + (d >>> 2) + (d >>> 3) + (d >>> 5);
        g = y - ((c >>> 2) + (c >>> 4) + (c >>> 5))
              - ((d >>> 1) + (d >>> 3) + (d >>> 4) + (d >>> 5));
        b = y + c + (c >>> 1) + (c >>> 2) + (c >>> 6);
        height = (model_height == 0) ? 1 : int'(model_height);
        last_col = (int'(col_pos) + 1 >= int'(model_width));
        last_row = (int'(row_pos) + 1 >= height);
        res.pixel_word = {clamp_channel(b), clamp_channel(g), clamp_channel(r)};
        res.dest_offset = 32'(model_stride) * 32'(row_pos) + 32'(col_pos);
        res.end_of_image = last_col && last_row;
        if (!last_col)
            col_pos = col_pos + DIM_W'(1);
        else
        begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + DIM_W'(1);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("tb_top: mismatch on %s: got %h, wanted %h at %0t",
                     what, got, exp_val, $time);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_IMAGE_WIDTH:  model_width  = value;
            REG_IMAGE_HEIGHT: model_height = value;
            REG_LINE_STRIDE:  model_stride = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
        ycc_sample_t s;
        s.luma      = y;
        s.blue_diff = cb;
        s.red_diff  = cr;
        pending_pixels.push_back(s);
    endtask

    // block is idle once nothing is queued, in flight or outstanding
    task automatic wait_idle();
        @(posedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(127 + $urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            3, 4, 5, 6: return 16'($urandom_range(2, 8));
            7: return 16'($urandom_range(9, 40));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || sample_taken)
        begin
            sample_taken = 1'b0;
            if (in_gap_left > 0)
            begin
                in_gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() == 0)
                in_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_gap_left = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else
            begin
                next_sample = pending_pixels.pop_front();
                in_valid  <= 1'b1;
                luma      <= next_sample.luma;
                blue_diff <= next_sample.blue_diff;
                red_diff  <= next_sample.red_diff;
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (out_stall_left > 0)
        begin
            out_stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            out_stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                taken_sample.luma      = luma;
                taken_sample.blue_diff = blue_diff;
                taken_sample.red_diff  = red_diff;
                expected_pixels.push_back(convert_and_advance(taken_sample));
                sample_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("result with nothing pending", 32'(pixel_word), '0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_word !== want.pixel_word)
                        report_mismatch("pixel_word", 32'(pixel_word), 32'(want.pixel_word));
                    if (dest_offset !== want.dest_offset)
                        report_mismatch("dest_offset", dest_offset, want.dest_offset);
                    if (end_of_image !== want.end_of_image)
                        report_mismatch("end_of_image", 32'(end_of_image),
                                        32'(want.end_of_image));
                    pixels_checked++;
                    if (want.end_of_image)
                        images_done++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset sizes: every pixel closes a one-pixel image
        queue_pixel(8'd0, 8'd128, 8'd128);
        queue_pixel(8'd255, 8'd0, 8'd255);
        wait_idle();

        // 4x2 image with channel extremes
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        write_reg(REG_LINE_STRIDE, 16'd10);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd255, 8'd0, 8'd255);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd16, 8'd127, 8'd129);
        wait_idle();

        // zero height counts as one row
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        write_reg(REG_LINE_STRIDE, 16'hFFFF);
        for (k = 0; k < 4; k++)
            queue_pixel(pick_sample(), pick_sample(), pick_sample());
        wait_idle();

        // zero width: one pixel per row
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        write_reg(REG_LINE_STRIDE, 16'd7);
        for (k = 0; k < 4; k++)
            queue_pixel(pick_sample(), pick_sample(), pick_sample());
        wait_idle();

        // shrink sizes mid-image so the counters sit past the new limits
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        write_reg(REG_LINE_STRIDE, 16'd9);
        for (k = 0; k < 5; k++)
            queue_pixel(pick_sample(), pick_sample(), pick_sample());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        queue_pixel(8'd200, 8'd60, 8'd190);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        queue_pixel(8'd40, 8'd220, 8'd30);
        queue_pixel(8'd90, 8'd10, 8'd250);
        wait_idle();

        while (random_pixels < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_WIDTH, pick_dim());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_HEIGHT, pick_dim());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_LINE_STRIDE, pick_dim());
            phase_len = $urandom_range(20, 120);
            split_at = ($urandom_range(0, 2) == 0) ? phase_len / 2 : 0;
            for (k = 0; k < phase_len; k++)
            begin
                // sender holds off until the converter has drained
                if (split_at != 0 && k == split_at)
                    wait_idle();
                queue_pixel(pick_sample(), pick_sample(), pick_sample());
            end
            random_pixels += phase_len;
            wait_idle();
            phase_count++;
        end

        // back-to-back tail at full rate, largest sizes first, then a 5x2 image
        calm = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_LINE_STRIDE, 16'hFFFF);
        for (k = 0; k < 60; k++)
            queue_pixel(pick_sample(), pick_sample(), pick_sample());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        for (k = 0; k < 40; k++)
            queue_pixel(pick_sample(), pick_sample(), pick_sample());
        wait_idle();

        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("results never delivered", 32'(expected_pixels.size()), '0);

        $display("tb_top: %0d pixels checked over %0d random phases, %0d images closed",
                 pixels_checked, phase_count, images_done);
        $display("tb_top: covered zero and full sizes, mid-image resizing and stalls");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ycc2rgb_pkg.sv
rtl/ycc2rgb_conv.sv
rtl/ycbcr_to_rgb_pixel_converter.sv
bench/tb_top.sv
